// ===== hw/rtl/crp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crp_pkg
// Shared types and constants of the table seating sampler.
// ----------------------------------------------------------------------------
package crp_pkg;

    // fixed field widths
    localparam int U_BITS       = 16;   // random fraction, Q0.16
    localparam int ALPHA_BITS   = 16;   // concentration, Q8.8
    localparam int ALPHA_FRAC   = 8;
    localparam int PREFIX_SHIFT = 24;   // 2^16 (u) * 2^8 (alpha scale)
    localparam int MUL_CNT_BITS = $clog2(U_BITS + 1);

    localparam logic ACT_SEAT   = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SCAN,
        ST_UPDATE,
        ST_SHIFT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [5:0]  table_index;
        logic        new_table;
        logic        table_removed;
        t_status     status;
        logic [15:0] customer_total;
        logic [6:0]  tables_in_use;
    } t_result;

endpackage
`default_nettype wire

// ===== hw/rtl/crp_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crp_mul
// Shift-add multiplier: one bit of the fraction per cycle.
// ----------------------------------------------------------------------------
module crp_mul #(
    parameter int MW = 25               // multiplicand width
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [MW-1:0]                  i_mcand,
    input  wire logic [crp_pkg::U_BITS-1:0]     i_mplier,
    output logic                                o_done,
    output logic [MW+crp_pkg::U_BITS-1:0]       o_product
);

    localparam int PW = MW + crp_pkg::U_BITS;
    localparam int CW = crp_pkg::MUL_CNT_BITS;

    logic [PW-1:0]              r_acc;
    logic [PW-1:0]              r_mc;
    logic [crp_pkg::U_BITS-1:0] r_mp;
    logic [CW-1:0]              r_cnt;
    logic                       r_busy;
    logic                       r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(crp_pkg::U_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_mc  <= {{crp_pkg::U_BITS{1'b0}}, i_mcand};
            r_mp  <= i_mplier;
        end else if (r_busy) begin
            if (r_mp[0]) begin
                r_acc <= r_acc + r_mc;
            end
            r_mc <= {r_mc[PW-2:0], 1'b0};
            r_mp <= {1'b0, r_mp[crp_pkg::U_BITS-1:1]};
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule
`default_nettype wire

// ===== hw/rtl/crp_tbl_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crp_tbl_mem
// Table count store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module crp_tbl_mem #(
    parameter int DEPTH = 64,
    parameter int DW    = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [DW-1:0]            i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [DW-1:0]                 o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

// ===== hw/rtl/crp_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crp_core
// Sequencer: threshold multiply, prefix scan, count update, delete shift.
// ----------------------------------------------------------------------------
module crp_core #(
    parameter int MAX_TABLES = 64,
    parameter int COUNT_BITS = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    input  wire logic                               i_action,
    input  wire logic [crp_pkg::U_BITS-1:0]         i_u,
    input  wire logic [crp_pkg::ALPHA_BITS-1:0]     i_alpha,
    output logic                                    o_ready,
    output logic                                    o_res_valid,
    input  wire logic                               i_res_take,
    output crp_pkg::t_result                        o_res
);

    localparam int AW = $clog2(MAX_TABLES);
    localparam int NW = AW + 1;
    localparam int CB = COUNT_BITS;
    localparam int MW = CB + crp_pkg::ALPHA_FRAC + 1;
    localparam int PW = MW + crp_pkg::U_BITS;

    crp_pkg::t_state  r_state, n_state;
    logic             r_act;
    logic [NW-1:0]    r_n;
    logic [CB-1:0]    r_s;
    logic [PW-1:0]    r_thresh;
    logic [CB-1:0]    r_prefix;
    logic [NW-1:0]    r_issue;
    logic [AW-1:0]    r_tgt;
    logic [CB-1:0]    r_cnt;
    logic             r_found;
    logic             r_rd_vld;
    logic [AW-1:0]    r_rd_idx;
    crp_pkg::t_result r_res;

    logic             w_rd_en, w_wr_en;
    logic [AW-1:0]    w_rd_addr, w_wr_addr;
    logic [CB-1:0]    w_wr_data, w_rd_data;
    logic             w_mul_start, w_mul_done;
    logic [MW-1:0]    w_mcand;
    logic [PW-1:0]    w_product;

    logic             w_refuse, w_open_first, w_full, w_empties, w_shift_need;
    logic             w_at_end, w_hit;
    logic [CB-1:0]    w_psum;
    logic [PW-1:0]    w_psum_sh;

    function automatic logic [5:0] f_idx(input logic [AW-1:0] x);
        logic [AW+5:0] t;
        t = {6'b0, x};
        return t[5:0];
    endfunction

    function automatic logic [6:0] f_tabs(input logic [NW-1:0] x);
        logic [NW+6:0] t;
        t = {7'b0, x};
        return t[6:0];
    endfunction

    function automatic logic [15:0] f_tot(input logic [CB-1:0] x);
        logic [CB+15:0] t;
        t = {16'b0, x};
        return t[15:0];
    endfunction

    crp_mul #(.MW(MW)) u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mul_start),
        .i_mcand   (w_mcand),
        .i_mplier  (i_u),
        .o_done    (w_mul_done),
        .o_product (w_product)
    );

    crp_tbl_mem #(.DEPTH(MAX_TABLES), .DW(CB)) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // seat: (S << 8) + alpha ; remove: S
    assign w_mcand = (i_action == crp_pkg::ACT_SEAT)
                   ? ({1'b0, r_s, {crp_pkg::ALPHA_FRAC{1'b0}}}
                      + {{(MW-crp_pkg::ALPHA_BITS){1'b0}}, i_alpha})
                   : {{(crp_pkg::ALPHA_FRAC+1){1'b0}}, r_s};

    assign w_refuse     = (i_action == crp_pkg::ACT_SEAT) ? (&r_s) : (r_n == '0);
    assign w_open_first = (i_action == crp_pkg::ACT_SEAT) && (r_n == '0);
    assign w_full       = (r_n == NW'(MAX_TABLES));
    assign w_empties    = (r_cnt == CB'(1));
    assign w_shift_need = (({1'b0, r_tgt} + NW'(1)) < r_n);

    // scan compare
    assign w_psum    = r_prefix + w_rd_data;
    assign w_psum_sh = {1'b0, w_psum, {crp_pkg::PREFIX_SHIFT{1'b0}}};
    assign w_at_end  = r_rd_vld && ({1'b0, r_rd_idx} == (r_n - NW'(1)));
    assign w_hit     = r_rd_vld &&
                       ((r_act == crp_pkg::ACT_SEAT) ? (w_psum_sh >= r_thresh)
                        : (w_psum > r_thresh[CB+crp_pkg::U_BITS-1:crp_pkg::U_BITS]));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            crp_pkg::ST_IDLE: begin
                if (i_start) begin
                    if (w_refuse) begin
                        n_state = crp_pkg::ST_DONE;
                    end else if (w_open_first) begin
                        n_state = crp_pkg::ST_UPDATE;
                    end else begin
                        n_state = crp_pkg::ST_MUL;
                    end
                end
            end
            crp_pkg::ST_MUL: begin
                if (w_mul_done) begin
                    n_state = crp_pkg::ST_SCAN;
                end
            end
            crp_pkg::ST_SCAN: begin
                if (w_hit || w_at_end) begin
                    n_state = crp_pkg::ST_UPDATE;
                end
            end
            crp_pkg::ST_UPDATE: begin
                if (r_act == crp_pkg::ACT_REMOVE && w_empties && w_shift_need) begin
                    n_state = crp_pkg::ST_SHIFT;
                end else begin
                    n_state = crp_pkg::ST_DONE;
                end
            end
            crp_pkg::ST_SHIFT: begin
                if (w_at_end) begin
                    n_state = crp_pkg::ST_DONE;
                end
            end
            crp_pkg::ST_DONE: begin
                if (i_res_take) begin
                    n_state = crp_pkg::ST_IDLE;
                end
            end
            default: n_state = crp_pkg::ST_IDLE;
        endcase
    end

    // datapath controls
    always_comb begin
        w_mul_start = 1'b0;
        w_rd_en     = 1'b0;
        w_rd_addr   = r_issue[AW-1:0];
        w_wr_en     = 1'b0;
        w_wr_addr   = r_tgt;
        w_wr_data   = r_cnt + CB'(1);
        case (r_state)
            crp_pkg::ST_IDLE: begin
                w_mul_start = i_start && !w_refuse && !w_open_first;
            end
            crp_pkg::ST_SCAN: begin
                w_rd_en = (r_issue < r_n) && !w_hit && !w_at_end;
            end
            crp_pkg::ST_UPDATE: begin
                if (r_act == crp_pkg::ACT_SEAT) begin
                    if (r_found) begin
                        w_wr_en = 1'b1;
                    end else if (!w_full) begin
                        w_wr_en   = 1'b1;
                        w_wr_addr = r_n[AW-1:0];
                        w_wr_data = CB'(1);
                    end
                end else if (!w_empties) begin
                    w_wr_en   = 1'b1;
                    w_wr_data = r_cnt - CB'(1);
                end
            end
            crp_pkg::ST_SHIFT: begin
                // move entry k down to k-1
                w_rd_en   = (r_issue < r_n);
                w_wr_en   = r_rd_vld;
                w_wr_addr = r_rd_idx - AW'(1);
                w_wr_data = w_rd_data;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= crp_pkg::ST_IDLE;
            r_n      <= '0;
            r_s      <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= w_rd_en;
            case (r_state)
                crp_pkg::ST_UPDATE: begin
                    if (r_act == crp_pkg::ACT_SEAT) begin
                        if (r_found) begin
                            r_s <= r_s + CB'(1);
                        end else if (!w_full) begin
                            r_s <= r_s + CB'(1);
                            r_n <= r_n + NW'(1);
                        end
                    end else begin
                        r_s <= r_s - CB'(1);
                        if (w_empties && !w_shift_need) begin
                            r_n <= r_n - NW'(1);
                        end
                    end
                end
                crp_pkg::ST_SHIFT: begin
                    if (w_at_end) begin
                        r_n <= r_n - NW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= w_rd_addr;
        if (w_rd_en) begin
            r_issue <= r_issue + NW'(1);
        end
        case (r_state)
            crp_pkg::ST_IDLE: begin
                if (i_start) begin
                    r_act                <= i_action;
                    r_found              <= 1'b0;
                    r_res.table_index    <= '0;
                    r_res.new_table      <= 1'b0;
                    r_res.table_removed  <= 1'b0;
                    r_res.status         <= (i_action == crp_pkg::ACT_SEAT)
                                            ? crp_pkg::STAT_FULL : crp_pkg::STAT_EMPTY;
                    r_res.customer_total <= f_tot(r_s);
                    r_res.tables_in_use  <= f_tabs(r_n);
                end
            end
            crp_pkg::ST_MUL: begin
                if (w_mul_done) begin
                    r_thresh <= w_product;
                    r_prefix <= '0;
                    r_issue  <= '0;
                end
            end
            crp_pkg::ST_SCAN: begin
                if (r_rd_vld) begin
                    r_prefix <= w_psum;
                end
                if (w_hit || w_at_end) begin
                    r_tgt   <= r_rd_idx;
                    r_cnt   <= w_rd_data;
                    r_found <= w_hit || (r_act == crp_pkg::ACT_REMOVE);
                end
            end
            crp_pkg::ST_UPDATE: begin
                r_issue <= {1'b0, r_tgt} + NW'(1);
                if (r_act == crp_pkg::ACT_SEAT) begin
                    if (r_found) begin
                        r_res.table_index    <= f_idx(r_tgt);
                        r_res.status         <= crp_pkg::STAT_OK;
                        r_res.customer_total <= f_tot(r_s + CB'(1));
                    end else if (!w_full) begin
                        r_res.table_index    <= f_idx(r_n[AW-1:0]);
                        r_res.new_table      <= 1'b1;
                        r_res.status         <= crp_pkg::STAT_OK;
                        r_res.customer_total <= f_tot(r_s + CB'(1));
                        r_res.tables_in_use  <= f_tabs(r_n + NW'(1));
                    end
                end else begin
                    r_res.table_index    <= f_idx(r_tgt);
                    r_res.table_removed  <= w_empties;
                    r_res.status         <= crp_pkg::STAT_OK;
                    r_res.customer_total <= f_tot(r_s - CB'(1));
                    r_res.tables_in_use  <= w_empties ? f_tabs(r_n - NW'(1)) : f_tabs(r_n);
                end
            end
            default: ;
        endcase
    end

    assign o_ready     = (r_state == crp_pkg::ST_IDLE);
    assign o_res_valid = (r_state == crp_pkg::ST_DONE);
    assign o_res       = r_res;

endmodule
`default_nettype wire

// ===== hw/rtl/crp_table_seating_sampler.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crp_table_seating_sampler
// Chinese restaurant process seating: keeps per-table customer counts and
// seats or removes one customer per input transaction.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  s_axis    in         tdata: random fraction u (Q0.16); tuser: action
//  m_axis    out        tdata: index, total, tables; tuser: new, removed, status
//  cfg       in         concentration alpha (Q8.8), reset 1.0
//
//  An add or remove runs the shift-add threshold multiply (load plus 16
//  steps), then the prefix scan over the tables with a registered memory
//  read, an update step and, when a table is deleted, a shift of every
//  later table down by one. Scan and shift together cover the list once.
//  Refused items go straight to the result; a seat on an empty list skips
//  the multiply and the scan.
//  s_axis_tready is high only while the sequencer is idle; the result sits
//  in an output register so the next transaction can be taken meanwhile.
//  A further result waits in the sequencer until that register drains.
//  Reset (synchronous, active low) empties the table list and sets alpha to
//  1.0; the count memory needs no clearing since only occupied entries are
//  ever read.
// ----------------------------------------------------------------------------
module crp_table_seating_sampler #(
    parameter int MAX_TABLES = 64,
    parameter int COUNT_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input transactions
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] random_fraction
    input  wire logic        s_axis_tuser,   // [0] action
    // result transactions
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [5:0] table_index, [21:6] customer_total,
                                             // [28:22] tables_in_use, [31:29] zero
    output logic [3:0]       m_axis_tuser,   // [0] new_table, [1] table_removed, [3:2] status
    // configuration
    input  wire logic        i_cfg_wr_en,
    input  wire logic [15:0] i_cfg_wr_data   // concentration
);

    localparam logic [crp_pkg::ALPHA_BITS-1:0] ALPHA_RESET = 16'd256;

    logic [crp_pkg::ALPHA_BITS-1:0] r_alpha;
    logic                           r_out_valid;
    crp_pkg::t_result               r_out;

    logic             w_core_ready;
    logic             w_core_valid;
    logic             w_slot_free;
    logic             w_accept;
    crp_pkg::t_result w_core_res;

    assign w_accept    = s_axis_tvalid && w_core_ready;
    // output register can take a new result when empty or being drained
    assign w_slot_free = !r_out_valid || m_axis_tready;

    crp_core #(
        .MAX_TABLES (MAX_TABLES),
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_accept),
        .i_action    (s_axis_tuser),
        .i_u         (s_axis_tdata),
        .i_alpha     (r_alpha),
        .o_ready     (w_core_ready),
        .o_res_valid (w_core_valid),
        .i_res_take  (w_slot_free),
        .o_res       (w_core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha     <= ALPHA_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_alpha <= i_cfg_wr_data;
            end
            if (w_core_valid && w_slot_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_core_valid && w_slot_free) begin
            r_out <= w_core_res;
        end
    end

    assign s_axis_tready = w_core_ready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out.tables_in_use, r_out.customer_total,
                            r_out.table_index};
    assign m_axis_tuser  = {r_out.status, r_out.table_removed, r_out.new_table};

endmodule
`default_nettype wire
